// ===== rtl/mbre_pkg.sv =====
`timescale 1ns / 1ps

package mbre_pkg;

  localparam int BUF_DEPTH_DEFAULT = 32;

  // Modbus CRC-16: reflected form, low byte sent first
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] SLAVE_ADDR_MIN = 8'h01;
  localparam logic [7:0] SLAVE_ADDR_MAX = 8'hF7;
  localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;

  localparam logic [4:0] DATA_LIMIT_MAX = 5'd27;
  localparam logic [4:0] MAX_DATA_RESET = 5'd20;

  // address, function, count ahead of the data, CRC after it
  localparam logic [5:0] FRAME_HEAD = 6'd3;
  localparam logic [5:0] FRAME_OVERHEAD = 6'd5;

  localparam logic STATUS_FRAME = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_TEST,
    ST_RD_ADDR,
    ST_RD_FUNC,
    ST_CNT,
    ST_CRC_RD,
    ST_CRC_LD,
    ST_CRC_SH,
    ST_CK_LO,
    ST_CK_HI,
    ST_CK_END,
    ST_NEXT,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_NOT_FOUND
  } scan_state_t;

  typedef struct packed {
    logic init;
    logic load;
    logic shift;
  } crc_ctrl_t;

  typedef struct packed {
    logic       status;
    logic [7:0] frame_byte;
    logic       frame_end;
  } res_item_t;

endpackage

// ===== rtl/mbre_byte_ram.sv =====
`timescale 1ns / 1ps

module mbre_byte_ram #(
  parameter int BUF_DEPTH = mbre_pkg::BUF_DEPTH_DEFAULT,
  localparam int AW = $clog2(BUF_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mbre_crc_bit.sv =====
`timescale 1ns / 1ps

// Bit-serial Modbus CRC: one data bit per shift, LSB first.
module mbre_crc_bit (
  input  logic                clk,
  input  mbre_pkg::crc_ctrl_t ctrl,
  input  logic [7:0]          din,
  output logic [15:0]         crc
);

  logic [7:0] sr;
  logic       fb;

  assign fb = crc[0] ^ sr[0];

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      crc <= mbre_pkg::CRC_INIT;
    end else if (ctrl.shift) begin
      crc <= {1'b0, crc[15:1]} ^ (fb ? mbre_pkg::CRC_POLY : 16'h0000);
    end
    if (ctrl.load) begin
      sr <= din;
    end else if (ctrl.shift) begin
      sr <= {1'b0, sr[7:1]};
    end
  end

endmodule

// ===== rtl/mbre_scan.sv =====
`timescale 1ns / 1ps

// Burst loader, frame search sequencer and result emitter.
module mbre_scan #(
  parameter int BUF_DEPTH = mbre_pkg::BUF_DEPTH_DEFAULT,
  localparam int AW = $clog2(BUF_DEPTH),
  localparam int CW = $clog2(BUF_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rx_valid,
  input  logic                burst_end,
  output logic                rx_stall,
  input  logic [4:0]          limit,
  input  logic                out_free,
  output logic                we,
  output logic [AW-1:0]       waddr,
  output logic [AW-1:0]       raddr,
  input  logic [7:0]          rdata,
  output mbre_pkg::crc_ctrl_t crc_ctrl,
  input  logic [15:0]         crc,
  output logic                res_load,
  output mbre_pkg::res_item_t res_data
);

  localparam int SW = CW + 6;

  mbre_pkg::scan_state_t state, state_next;

  logic [CW-1:0] fill;
  logic [CW-1:0] len;
  logic [AW-1:0] start;
  logic [5:0]    k;
  logic [2:0]    bit_cnt;
  logic [4:0]    bc;
  logic          lo_ok;

  logic          accept;
  logic          room;
  logic [SW-1:0] start_w;
  logic [SW-1:0] len_w;
  logic [5:0]    flen;
  logic [5:0]    crc_len;
  logic          start_fits;
  logic          addr_ok;
  logic          cnt_ok;
  logic          crc_ok;
  logic [SW-1:0] rd_sum;
  logic [5:0]    rd_off;

  assign accept  = rx_valid && !rx_stall;
  assign room    = fill < CW'(BUF_DEPTH);
  assign start_w = SW'(start);
  assign len_w   = SW'(len);
  assign flen    = 6'(bc) + mbre_pkg::FRAME_OVERHEAD;
  assign crc_len = 6'(bc) + mbre_pkg::FRAME_HEAD;

  assign start_fits = start_w + SW'(mbre_pkg::FRAME_OVERHEAD) <= len_w;
  assign addr_ok    = rdata >= mbre_pkg::SLAVE_ADDR_MIN && rdata <= mbre_pkg::SLAVE_ADDR_MAX;
  // byte count held in rdata during ST_CNT
  assign cnt_ok = rdata != 8'd0 && rdata <= 8'(limit)
               && start_w + SW'(rdata[4:0]) + SW'(mbre_pkg::FRAME_OVERHEAD) <= len_w;
  assign crc_ok = lo_ok && rdata == crc[15:8];

  assign we    = accept && room;
  assign waddr = fill[AW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      mbre_pkg::ST_LOAD: begin
        if (accept && burst_end) begin
          state_next = mbre_pkg::ST_TEST;
        end
      end
      mbre_pkg::ST_TEST: begin
        state_next = start_fits ? mbre_pkg::ST_RD_ADDR : mbre_pkg::ST_NOT_FOUND;
      end
      mbre_pkg::ST_RD_ADDR: begin
        state_next = addr_ok ? mbre_pkg::ST_RD_FUNC : mbre_pkg::ST_NEXT;
      end
      mbre_pkg::ST_RD_FUNC: begin
        state_next = (rdata == mbre_pkg::FUNC_READ_HOLDING) ? mbre_pkg::ST_CNT
                                                           : mbre_pkg::ST_NEXT;
      end
      mbre_pkg::ST_CNT: begin
        state_next = cnt_ok ? mbre_pkg::ST_CRC_RD : mbre_pkg::ST_NEXT;
      end
      mbre_pkg::ST_CRC_RD: state_next = mbre_pkg::ST_CRC_LD;
      mbre_pkg::ST_CRC_LD: state_next = mbre_pkg::ST_CRC_SH;
      mbre_pkg::ST_CRC_SH: begin
        if (bit_cnt == 3'd7) begin
          state_next = (k + 6'd1 == crc_len) ? mbre_pkg::ST_CK_LO : mbre_pkg::ST_CRC_RD;
        end
      end
      mbre_pkg::ST_CK_LO: state_next = mbre_pkg::ST_CK_HI;
      mbre_pkg::ST_CK_HI: state_next = mbre_pkg::ST_CK_END;
      mbre_pkg::ST_CK_END: begin
        state_next = crc_ok ? mbre_pkg::ST_EMIT_RD : mbre_pkg::ST_NEXT;
      end
      mbre_pkg::ST_NEXT:    state_next = mbre_pkg::ST_TEST;
      mbre_pkg::ST_EMIT_RD: state_next = mbre_pkg::ST_EMIT_LD;
      mbre_pkg::ST_EMIT_LD: begin
        if (out_free) begin
          state_next = (k + 6'd1 == flen) ? mbre_pkg::ST_LOAD : mbre_pkg::ST_EMIT_RD;
        end
      end
      mbre_pkg::ST_NOT_FOUND: begin
        if (out_free) begin
          state_next = mbre_pkg::ST_LOAD;
        end
      end
      default: state_next = mbre_pkg::ST_LOAD;
    endcase
  end

  // read offset from the frame start, stall, CRC control and result load per state
  always_comb begin
    rx_stall = 1'b1;
    rd_off   = k;
    crc_ctrl = '0;
    res_load = 1'b0;
    res_data = '0;
    unique case (state)
      mbre_pkg::ST_LOAD:    rx_stall = 1'b0;
      mbre_pkg::ST_TEST:    rd_off = 6'd0;
      mbre_pkg::ST_RD_ADDR: rd_off = 6'd1;
      mbre_pkg::ST_RD_FUNC: rd_off = 6'd2;
      mbre_pkg::ST_CNT:     crc_ctrl.init = 1'b1;
      mbre_pkg::ST_CRC_LD:  crc_ctrl.load = 1'b1;
      mbre_pkg::ST_CRC_SH:  crc_ctrl.shift = 1'b1;
      mbre_pkg::ST_CK_LO:   rd_off = crc_len;
      mbre_pkg::ST_CK_HI:   rd_off = crc_len + 6'd1;
      mbre_pkg::ST_EMIT_LD: begin
        res_load            = out_free;
        res_data.status     = mbre_pkg::STATUS_FRAME;
        res_data.frame_byte = rdata;
        res_data.frame_end  = (k + 6'd1 == flen);
      end
      mbre_pkg::ST_NOT_FOUND: begin
        res_load            = out_free;
        res_data.status     = mbre_pkg::STATUS_NOT_FOUND;
        res_data.frame_byte = 8'd0;
        res_data.frame_end  = 1'b1;
      end
      default: ;
    endcase
  end

  assign rd_sum = start_w + SW'(rd_off);
  assign raddr  = rd_sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbre_pkg::ST_LOAD;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (burst_end) begin
          fill <= '0;
        end else if (room) begin
          fill <= fill + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mbre_pkg::ST_LOAD: begin
        start <= '0;
        len   <= room ? fill + CW'(1) : fill;
      end
      mbre_pkg::ST_CNT: begin
        bc <= rdata[4:0];
        k  <= '0;
      end
      mbre_pkg::ST_CRC_LD: bit_cnt <= '0;
      mbre_pkg::ST_CRC_SH: begin
        bit_cnt <= bit_cnt + 3'd1;
        if (bit_cnt == 3'd7) begin
          k <= k + 6'd1;
        end
      end
      mbre_pkg::ST_CK_HI:  lo_ok <= (rdata == crc[7:0]);
      mbre_pkg::ST_CK_END: k <= '0;
      mbre_pkg::ST_NEXT:   start <= start + AW'(1);
      mbre_pkg::ST_EMIT_LD: begin
        if (out_free) begin
          k <= k + 6'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/modbus_read_response_extractor_unit.sv =====
`timescale 1ns / 1ps

// Modbus function-3 response extractor. Received RS485 bytes (bus echo and a
// slave reply) are taken one item per cycle while loading, into a BUF_DEPTH
// byte buffer; bytes past the depth are dropped. The item with burst_end set
// closes the burst and starts a search over start positions in ascending order
// for a frame with slave address 01..F7, function 03, byte count
// 1..max_data_bytes (held at 27 above that), lying wholly in the buffer and
// carrying a good Modbus CRC-16. The first such frame goes out one result item
// per byte (status 0, frame_end on the CRC high byte), otherwise a single item
// with status 1, frame_byte 0 and frame_end 1. A start position whose header is
// refused costs up to the address, function and count reads plus the step on;
// each byte covered by the CRC costs one buffer read, one load and eight shifts
// of the bit-serial CRC unit, then come the check of both CRC bytes and, when
// it fails, the step on. A frame then costs a buffer read and an output load
// per emitted byte; emission and the not-found item wait on any output stall.
// The single buffer read port and the one-bit CRC datapath set the pace of the
// search. rx_stall is high for the whole search and emission. max_data_bytes
// may be written only while the block is idle; cfg_ready is always high.

module modbus_read_response_extractor_unit #(
  parameter int BUF_DEPTH = mbre_pkg::BUF_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  // received byte items
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  logic       burst_end,
  // result items
  output logic       res_valid,
  input  logic       res_stall,
  output logic       status,
  output logic [7:0] frame_byte,
  output logic       frame_end,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] max_data_bytes
);

  localparam int AW = $clog2(BUF_DEPTH);

  logic [4:0]          max_data;
  logic [4:0]          limit;
  logic                out_free;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic [7:0]          rdata;
  logic [15:0]         crc;
  mbre_pkg::crc_ctrl_t crc_ctrl;
  logic                res_load;
  mbre_pkg::res_item_t res_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_data <= mbre_pkg::MAX_DATA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_data <= max_data_bytes;
    end
  end

  // longest frame is 32 bytes
  assign limit = (max_data > mbre_pkg::DATA_LIMIT_MAX) ? mbre_pkg::DATA_LIMIT_MAX : max_data;

  // output register: the sequencer loads it only when empty or draining
  assign out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status     <= res_data.status;
      frame_byte <= res_data.frame_byte;
      frame_end  <= res_data.frame_end;
    end
  end

  mbre_byte_ram #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(rx_byte),
    .raddr(raddr),
    .rdata(rdata)
  );

  mbre_crc_bit u_crc (
    .clk (clk),
    .ctrl(crc_ctrl),
    .din (rdata),
    .crc (crc)
  );

  mbre_scan #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .burst_end(burst_end),
    .rx_stall (rx_stall),
    .limit    (limit),
    .out_free (out_free),
    .we       (we),
    .waddr    (waddr),
    .raddr    (raddr),
    .rdata    (rdata),
    .crc_ctrl (crc_ctrl),
    .crc      (crc),
    .res_load (res_load),
    .res_data (res_data)
  );

`ifndef SYNTHESIS
  // a not-found item is always the last of its burst and carries no byte
  a_not_found_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == mbre_pkg::STATUS_NOT_FOUND |-> frame_end && frame_byte == 8'd0)
    else $error("not-found item malformed");

  // no result is produced while bytes are being loaded
  a_no_result_in_load: assert property (@(posedge clk) disable iff (rst)
    !rx_stall |-> !res_load)
    else $error("result produced during load");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("pending result overwritten");

  // no buffer write while the search runs
  a_no_write_in_search: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> !we)
    else $error("buffer written during search");
`endif

endmodule
